// ===== src/stepper_valve_position_driver_core_macros.svh =====
// Assertion macros for the stepper valve position driver.
// Used by the modules that assert; expects aclk and aresetn in scope.
`ifndef STEPPER_VALVE_POSITION_DRIVER_CORE_MACROS_SVH
`define STEPPER_VALVE_POSITION_DRIVER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SVPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SVPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/svpd_pkg.sv =====
// Shared types, codes and the half-step coil table for the valve driver.
// No dependencies.
package svpd_pkg;

    localparam int CMD_W           = 3;
    localparam int AMOUNT_W        = 16;
    localparam int PHASE_SEL_W     = 4;
    localparam int PHASE_W         = 3;
    localparam int COIL_W          = 4;
    localparam int POS_OUT_W       = 16;
    localparam int STEP_INTERVAL_W = 10;
    localparam int FULL_OPEN_W     = 16;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [STEP_INTERVAL_W-1:0] STEP_INTERVAL_RESET = 10'd10;
    localparam logic [FULL_OPEN_W-1:0]     FULL_OPEN_RESET     = 16'd500;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_OPEN  = 3'd1,
        CMD_CLOSE = 3'd2,
        CMD_MOVE  = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_HOLD  = 3'd5
    } svpd_cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STEP_INTERVAL = 1'b0,
        CFG_FULL_OPEN     = 1'b1
    } svpd_cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [AMOUNT_W-1:0]    amount;
        logic [PHASE_SEL_W-1:0] phase_select;
    } svpd_in_t;

    typedef struct packed {
        logic [COIL_W-1:0]    coil_pattern;
        logic                 pattern_written;
        logic                 coils_released;
        logic                 busy_res;
        logic [POS_OUT_W-1:0] position;
        logic                 accepted;
    } svpd_out_t;

    typedef struct packed {
        logic [STEP_INTERVAL_W-1:0] step_interval;
        logic [FULL_OPEN_W-1:0]     full_open_position;
    } svpd_cfg_t;

    // half-step sequence, bit0 A .. bit3 D
    function automatic logic [COIL_W-1:0] coil_pattern_f(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        unique case (ph)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/svpd_in_stage.sv =====
// Input register for command beats.
// Depends on svpd_pkg.
module svpd_in_stage
    import svpd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  svpd_in_t s_item,
    output logic     item_valid,
    output svpd_in_t item,
    input  logic     item_take
);

    logic     valid_reg;
    logic     valid_next;
    svpd_in_t item_reg;

    // free when empty or when the held beat is taken this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/svpd_step_logic.sv =====
// Valve state registers and the per-beat update (targets, ticks, hold, stop).
// Depends on svpd_pkg and the assertion macro header.
`include "stepper_valve_position_driver_core_macros.svh"

module svpd_step_logic
    import svpd_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  svpd_in_t  item,
    input  svpd_cfg_t cfg,
    output svpd_out_t result
);

    localparam int RAW_W = AMOUNT_W + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0]   pos_reg,    pos_next;
    logic [POSITION_BITS-1:0]   target_reg, target_next;
    logic                       moving_reg, moving_next;
    logic [PHASE_W-1:0]         phase_reg,  phase_next;
    logic                       closing_reg, closing_next;
    logic [STEP_INTERVAL_W-1:0] count_reg,  count_next;

    logic [POSITION_BITS-1:0]   lim;
    logic [RAW_W-1:0]           pos_wide;
    logic [RAW_W-1:0]           amount_wide;
    logic [RAW_W-1:0]           raw_target;
    logic [POSITION_BITS-1:0]   clamped;
    logic [STEP_INTERVAL_W-1:0] count_inc;
    logic [POSITION_BITS-1:0]   stepped_pos;

    // clamp limit: smaller of full-open and the largest position
    always_comb begin
        if (cfg.full_open_position < FULL_OPEN_W'(POS_MAX)) begin
            lim = cfg.full_open_position[POSITION_BITS-1:0];
        end else begin
            lim = POS_MAX;
        end
    end

    assign pos_wide    = RAW_W'(pos_reg);
    assign amount_wide = RAW_W'(item.amount);

    // unclamped target per command
    always_comb begin
        unique case (svpd_cmd_t'(item.cmd))
            CMD_OPEN:  raw_target = pos_wide + amount_wide;
            CMD_CLOSE: raw_target = (amount_wide > pos_wide) ? '0 : (pos_wide - amount_wide);
            default:   raw_target = amount_wide;
        endcase
    end

    assign clamped = (raw_target > RAW_W'(lim)) ? lim : raw_target[POSITION_BITS-1:0];

    // interval counter advance on a tick
    assign count_inc = (count_reg < cfg.step_interval) ? count_reg + 1'b1 : count_reg;

    // one step with saturation at both ends
    always_comb begin
        if (!closing_reg) begin
            stepped_pos = (pos_reg < lim) ? pos_reg + 1'b1 : pos_reg;
        end else begin
            stepped_pos = (pos_reg != '0) ? pos_reg - 1'b1 : pos_reg;
        end
    end

    // next state and result for the beat
    always_comb begin
        pos_next     = pos_reg;
        target_next  = target_reg;
        moving_next  = moving_reg;
        phase_next   = phase_reg;
        closing_next = closing_reg;
        count_next   = count_reg;

        result                 = '0;
        result.accepted        = 1'b1;

        unique case (item.cmd)
            CMD_TICK: begin
                if (moving_reg) begin
                    if (count_inc >= cfg.step_interval) begin
                        count_next             = '0;
                        result.coil_pattern    = coil_pattern_f(phase_reg);
                        result.pattern_written = 1'b1;
                        pos_next               = stepped_pos;
                        phase_next             = closing_reg ? phase_reg - 1'b1
                                                             : phase_reg + 1'b1;
                        if (stepped_pos == target_reg) begin
                            moving_next           = 1'b0;
                            result.coils_released = 1'b1;
                        end
                    end else begin
                        count_next = count_inc;
                    end
                end
            end
            CMD_OPEN, CMD_CLOSE, CMD_MOVE: begin
                target_next = clamped;
                count_next  = '0;
                if (clamped == pos_reg) begin
                    moving_next           = 1'b0;
                    result.coils_released = 1'b1;
                end else begin
                    closing_next = (clamped < pos_reg);
                    moving_next  = 1'b1;
                end
            end
            CMD_STOP: begin
                moving_next           = 1'b0;
                count_next            = '0;
                result.coils_released = 1'b1;
            end
            CMD_HOLD: begin
                if (item.phase_select[PHASE_SEL_W-1]) begin
                    result.accepted = 1'b0;
                end else begin
                    moving_next            = 1'b0;
                    count_next             = '0;
                    phase_next             = item.phase_select[PHASE_W-1:0];
                    result.coil_pattern    = coil_pattern_f(item.phase_select[PHASE_W-1:0]);
                    result.pattern_written = 1'b1;
                end
            end
            default: begin
            end
        endcase

        result.busy_res = moving_next;
        result.position = POS_OUT_W'(pos_next);
    end

    // state update, one beat per fire
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            target_reg  <= '0;
            moving_reg  <= 1'b0;
            phase_reg   <= '0;
            closing_reg <= 1'b0;
            count_reg   <= '0;
        end else if (fire) begin
            pos_reg     <= pos_next;
            target_reg  <= target_next;
            moving_reg  <= moving_next;
            phase_reg   <= phase_next;
            closing_reg <= closing_next;
            count_reg   <= count_next;
        end
    end

    // a move in progress never sits on its target
    `SVPD_ASSERT_IMP(a_moving_off_target, moving_reg, pos_reg != target_reg, "moving at target")
    // the counter only runs during a move
    `SVPD_ASSERT_IMP(a_idle_count_clear, !moving_reg, count_reg == '0, "count set while idle")
    // a rejected hold leaves no drive or release
    `SVPD_ASSERT_IMP(a_reject_quiet, fire && !result.accepted,
        !result.pattern_written && !result.coils_released, "rejected hold drove coils")
    // state holds between beats
    `SVPD_ASSERT_NEXT(a_state_hold, !fire, $stable(pos_reg) && $stable(phase_reg),
        "state moved without a beat")

endmodule

// ===== src/svpd_out_stage.sv =====
// Result register for result beats.
// Depends on svpd_pkg.
module svpd_out_stage
    import svpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  svpd_out_t result,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output svpd_out_t m_result
);

    logic      valid_reg;
    logic      valid_next;
    svpd_out_t result_reg;

    // room when empty or when the held beat leaves this cycle
    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== src/stepper_valve_position_driver_core.sv =====
// Top level of the stepper valve position driver: config registers and stage wiring.
// Depends on svpd_pkg, svpd_in_stage, svpd_step_logic and svpd_out_stage.
//
// Takes one command beat per cycle and returns one result beat per command. The result
// passes through the input register, then the update logic into the result register,
// before it is presented on m_valid, with a sustained rate of one beat per cycle while
// m_ready is high.
// Ticks count toward step_interval; a step drives the current half-step pattern,
// moves the phase and the position by one. Configuration writes take effect at the
// next clock edge and are meant for times when no beat is in flight.
module stepper_valve_position_driver_core
    import svpd_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  svpd_in_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output svpd_out_t              m_result
);

    svpd_cfg_t cfg_reg;
    logic      item_valid;
    svpd_in_t  item;
    logic      can_load;
    logic      fire;
    svpd_out_t result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval      <= STEP_INTERVAL_RESET;
            cfg_reg.full_open_position <= FULL_OPEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (svpd_cfg_idx_t'(cfg_index))
                CFG_STEP_INTERVAL:
                    cfg_reg.step_interval <= cfg_wdata[STEP_INTERVAL_W-1:0];
                default:
                    cfg_reg.full_open_position <= cfg_wdata[FULL_OPEN_W-1:0];
            endcase
        end
    end

    // a beat is processed when one is held and the result register has room
    assign fire = item_valid && can_load;

    svpd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    svpd_step_logic #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    svpd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule

// ===== test/svpd_drive_checker.sv =====
// Result checker for the stepper valve position driver: watches config writes and both channels.
// Predicts each result beat from its own model of the valve state and compares it.
// Depends on svpd_pkg.
`timescale 1ns / 1ps

module svpd_drive_checker
    import svpd_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  svpd_in_t               s_item,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  svpd_out_t              m_result,
    output int                     mismatch_count,
    output int                     pending_count,
    output int                     result_count,
    output int                     drive_count
);

    localparam logic [15:0] POS_MASK = 16'((32'd1 << POS_BITS) - 1);
    // half-step coil sequence, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

    // predicted valve state and register copies
    logic [9:0]  interval_reg;
    logic [15:0] full_open_reg;
    logic [15:0] valve_pos;
    logic [15:0] target_pos;
    logic        moving;
    logic [2:0]  phase;
    logic        closing;
    logic [15:0] tick_count;

    svpd_out_t expected_results[$];
    svpd_out_t want;
    svpd_out_t got;

    // clamp a new target and start or end the move
    function automatic logic aim_valve(input logic [16:0] goal, input logic [15:0] lim);
        logic [16:0] clamped;
        clamped    = (goal > {1'b0, lim}) ? {1'b0, lim} : goal;
        target_pos = clamped[15:0] & POS_MASK;
        tick_count = '0;
        if (target_pos == valve_pos) begin
            moving = 1'b0;
            return 1'b1;
        end
        closing = (target_pos < valve_pos);
        moving  = 1'b1;
        return 1'b0;
    endfunction

    // next result beat for one command, updating the predicted state
    function automatic svpd_out_t predict_drive(input svpd_in_t it);
        svpd_out_t   r;
        logic [15:0] lim;
        r          = '0;
        r.accepted = 1'b1;
        lim        = (full_open_reg < POS_MASK) ? full_open_reg : POS_MASK;
        case (it.cmd)
            CMD_TICK: begin
                if (moving) begin
                    if (tick_count < interval_reg) tick_count = tick_count + 16'd1;
                    if (tick_count >= interval_reg) begin
                        tick_count        = '0;
                        r.coil_pattern    = HALF_STEP[phase*4 +: 4];
                        r.pattern_written = 1'b1;
                        if (!closing) begin
                            if (valve_pos < lim) valve_pos = (valve_pos + 16'd1) & POS_MASK;
                            phase = phase + 3'd1;
                        end else begin
                            if (valve_pos != 16'd0) valve_pos = valve_pos - 16'd1;
                            phase = phase - 3'd1;
                        end
                        // arrival releases the coils
                        if (valve_pos == target_pos) begin
                            moving           = 1'b0;
                            r.coils_released = 1'b1;
                        end
                    end
                end
            end
            CMD_OPEN: begin
                r.coils_released = aim_valve({1'b0, valve_pos} + {1'b0, it.amount}, lim);
            end
            CMD_CLOSE: begin
                r.coils_released = aim_valve((it.amount > valve_pos) ? 17'd0 :
                                             {1'b0, valve_pos - it.amount}, lim);
            end
            CMD_MOVE: begin
                r.coils_released = aim_valve({1'b0, it.amount}, lim);
            end
            CMD_STOP: begin
                moving           = 1'b0;
                tick_count       = '0;
                r.coils_released = 1'b1;
            end
            CMD_HOLD: begin
                if (it.phase_select >= 4'd8) begin
                    r.accepted = 1'b0;
                end else begin
                    moving            = 1'b0;
                    tick_count        = '0;
                    phase             = it.phase_select[2:0];
                    r.coil_pattern    = HALF_STEP[phase*4 +: 4];
                    r.pattern_written = 1'b1;
                end
            end
            default: ;
        endcase
        r.busy_res = moving;
        r.position = valve_pos;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  = STEP_INTERVAL_RESET;
            full_open_reg = FULL_OPEN_RESET;
            valve_pos     = '0;
            target_pos    = '0;
            moving        = 1'b0;
            phase         = '0;
            closing       = 1'b0;
            tick_count    = '0;
            expected_results.delete();
            pending_count = 0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_STEP_INTERVAL: interval_reg  = cfg_wdata[STEP_INTERVAL_W-1:0];
                    CFG_FULL_OPEN:     full_open_reg = cfg_wdata[FULL_OPEN_W-1:0];
                    default: ;
                endcase
            end
            // result beat against the oldest expectation
            if (m_valid && m_ready) begin
                got = m_result;
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"unexpected result beat: ",
                                  "pat=%h wr=%b rel=%b busy=%b pos=%0d acc=%b"},
                                 got.coil_pattern, got.pattern_written, got.coils_released,
                                 got.busy_res, got.position, got.accepted);
                end else begin
                    want = expected_results.pop_front();
                    if (got.coil_pattern !== want.coil_pattern ||
                        got.pattern_written !== want.pattern_written ||
                        got.coils_released !== want.coils_released ||
                        got.busy_res !== want.busy_res ||
                        got.position !== want.position ||
                        got.accepted !== want.accepted) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d mismatch: expected pat=%h wr=%b rel=%b ",
                                      "busy=%b pos=%0d acc=%b, got pat=%h wr=%b rel=%b ",
                                      "busy=%b pos=%0d acc=%b"},
                                     result_count, want.coil_pattern, want.pattern_written,
                                     want.coils_released, want.busy_res, want.position,
                                     want.accepted, got.coil_pattern, got.pattern_written,
                                     got.coils_released, got.busy_res, got.position, got.accepted);
                    end
                end
            end
            // command beat into the prediction
            if (s_valid && s_ready) begin
                want = predict_drive(s_item);
                if (want.pattern_written) drive_count++;
                expected_results.push_back(want);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== test/stepper_valve_position_driver_core_tb.sv =====
// Testbench top for the stepper valve position driver: clock, reset, stimulus and verdict.
// Depends on svpd_pkg, stepper_valve_position_driver_core and svpd_drive_checker.
`timescale 1ns / 1ps

module stepper_valve_position_driver_core_tb;
    import svpd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    svpd_in_t               s_item;
    logic                   m_valid;
    logic                   m_ready;
    svpd_out_t              m_result;

    int mismatches;
    int pending;
    int results_seen;
    int coil_drives;
    int beats_sent   = 0;
    int settings_run = 0;
    bit gaps_on      = 1'b1;
    bit hold_req     = 1'b0;
    int ready_gap_left;

    always #2 aclk = ~aclk;

    stepper_valve_position_driver_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    svpd_drive_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .result_count   (results_seen),
        .drive_count    (coil_drives)
    );

    // idle length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one command beat, then an optional sender gap
    task automatic offer(input logic [CMD_W-1:0] c, input logic [AMOUNT_W-1:0] amt,
                         input logic [PHASE_SEL_W-1:0] sel);
        int g;
        s_valid             <= 1'b1;
        s_item.cmd          <= c;
        s_item.amount       <= amt;
        s_item.phase_select <= sel;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        g = 0;
        if (gaps_on && $urandom_range(0, 99) >= 55) g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic tick_run(input int n);
        repeat (n) offer(CMD_TICK, AMOUNT_W'($urandom), PHASE_SEL_W'($urandom));
    endtask

    // drain every expected result, then let the pipeline go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random phase: mostly a move command followed by a run of ticks
    task automatic run_phase(input int iv, input int fo, input int budget);
        int               sent;
        int               r;
        int               nt;
        int               span;
        logic [CMD_W-1:0] c;
        logic [15:0]      amt;
        settle();
        put_cfg(CFG_STEP_INTERVAL, CFG_DATA_W'(iv));
        put_cfg(CFG_FULL_OPEN, CFG_DATA_W'(fo));
        settings_run++;
        sent = 0;
        span = (fo < 40) ? fo : 40;
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                case ($urandom_range(0, 2))
                    0:       c = CMD_OPEN;
                    1:       c = CMD_CLOSE;
                    default: c = CMD_MOVE;
                endcase
                if ($urandom_range(0, 9) == 0) amt = 16'($urandom);
                else if (c == CMD_MOVE)        amt = 16'($urandom_range(0, span + 2));
                else                           amt = 16'($urandom_range(0, 12));
                offer(c, amt, PHASE_SEL_W'($urandom));
                sent++;
                nt = (iv > 8 && iv <= 300) ? iv + $urandom_range(0, 3) : $urandom_range(1, 24);
                repeat (nt) begin
                    if (sent < budget) begin
                        r = $urandom_range(0, 99);
                        if (r < 3)
                            offer(CMD_STOP, AMOUNT_W'($urandom), PHASE_SEL_W'($urandom));
                        else if (r < 6)
                            offer(CMD_HOLD, AMOUNT_W'($urandom),
                                  PHASE_SEL_W'($urandom_range(0, 7)));
                        else
                            offer(CMD_TICK, AMOUNT_W'($urandom), PHASE_SEL_W'($urandom));
                        sent++;
                    end
                end
            end else begin
                offer(CMD_W'($urandom_range(0, 7)), AMOUNT_W'($urandom),
                      PHASE_SEL_W'($urandom));
                sent++;
            end
        end
    endtask

    // receiver: random stalls, a long hold-off on request
    initial begin
        m_ready        = 1'b0;
        ready_gap_left = 0;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (!gaps_on) begin
                    m_ready <= 1'b1;
                end else if (ready_gap_left > 0) begin
                    m_ready <= 1'b0;
                    ready_gap_left--;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0) ready_gap_left = gap_len();
                end
                @(posedge aclk);
            end
        end
    end

    // run limit
    initial begin
        #3_000_000;
        $display("timeout with %0d results still expected", pending);
        $display("status: fail");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle commands, hold range, short moves, retarget and arrival
        put_cfg(CFG_STEP_INTERVAL, 16'd2);
        put_cfg(CFG_FULL_OPEN, 16'd500);
        settings_run++;
        offer(CMD_TICK, 16'h0000, 4'h0);
        offer(CMD_STOP, 16'h0000, 4'h0);
        offer(CMD_HOLD, 16'hFFFF, 4'hF);
        offer(CMD_HOLD, 16'h0000, 4'h8);
        offer(CMD_HOLD, 16'h0000, 4'h7);
        offer(CMD_HOLD, 16'hFFFF, 4'h0);
        offer(CMD_OPEN, 16'd3, 4'h0);
        tick_run(6);
        offer(CMD_MOVE, 16'd3, 4'h0);
        offer(CMD_CLOSE, 16'd0, 4'h0);
        offer(CMD_OPEN, 16'hFFFF, 4'h0);
        tick_run(2);
        offer(CMD_CLOSE, 16'hFFFF, 4'hF);
        tick_run(8);
        offer(CMD_SPARE_6, 16'hFFFF, 4'hF);
        offer(CMD_SPARE_7, 16'h0000, 4'h0);

        // random phases over several register settings
        run_phase(0, 65535, 150);
        gaps_on = 1'b0;
        run_phase(0, 60, 200);
        gaps_on = 1'b1;
        run_phase(1, 20, 180);
        run_phase(3, 0, 120);
        run_phase(1023, 1, 120);
        run_phase(200, 500, 250);

        // receiver holds off while the sender keeps offering
        settle();
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        repeat (40) offer(CMD_W'($urandom_range(0, 7)), AMOUNT_W'($urandom),
                          PHASE_SEL_W'($urandom));
        gaps_on = 1'b1;

        run_phase(1, 40, 200);
        settle();

        $display("sent %0d command beats over %0d register settings", beats_sent, settings_run);
        $display("checked %0d result beats, %0d of them driving the coils",
                 results_seen, coil_drives);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
